>>> rtl/assert_macros.svh
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression holds at every clock edge
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, expr, msg)
`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> rtl/i2da_pkg.sv
`default_nettype none

package i2da_pkg;

  // width of the signed input value
  localparam int VALUE_WIDTH = 32;

  // decimal digits needed for any magnitude up to 2^VALUE_WIDTH
  localparam int MAX_DIGITS = ((VALUE_WIDTH * 1233) >> 12) + 1;

  // the conversion unit takes four magnitude bits per cycle
  localparam int BITS_PER_STEP = 4;
  localparam int NUM_STEPS     = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int MAG_WIDTH     = NUM_STEPS * BITS_PER_STEP;
  localparam int BCD_WIDTH     = MAX_DIGITS * 4;

  localparam int DIG_IDX_W = $clog2(MAX_DIGITS);
  localparam int DIG_CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int STEP_W    = (NUM_STEPS > 1) ? $clog2(NUM_STEPS) : 1;

  // ascii codes
  localparam int CHAR_W = 8;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // status of the conversion unit
  typedef struct packed {
    logic busy;
    logic done;
  } dabble_stat_t;

endpackage

`default_nettype wire

>>> rtl/i2da_in_if.sv
`default_nettype none

interface i2da_in_if;
  import i2da_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

>>> rtl/i2da_out_if.sv
`default_nettype none

interface i2da_out_if;
  import i2da_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

>>> rtl/i2da_dabble.sv
`default_nettype none

`include "assert_macros.svh"

module i2da_dabble (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              load,
  input  logic [i2da_pkg::MAG_WIDTH-1:0]    load_mag,
  output i2da_pkg::dabble_stat_t            stat,
  output logic [i2da_pkg::BCD_WIDTH-1:0]    bcd,
  output logic [i2da_pkg::DIG_CNT_W-1:0]    ndig
);
  import i2da_pkg::*;

  logic [MAG_WIDTH-1:0] mag_r, mag_nxt;
  logic [BCD_WIDTH-1:0] bcd_r, bcd_nxt;
  logic [DIG_CNT_W-1:0] ndig_r, ndig_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;

  logic [MAG_WIDTH-1:0] mag_v;
  logic [BCD_WIDTH-1:0] bcd_v;
  logic [DIG_CNT_W-1:0] nd_v;
  logic [DIG_IDX_W-1:0] top_idx;
  logic                 top_nz;

  // shift-and-add-3 unit: four magnitude bits per cycle, tracking digit count
  always_comb begin
    mag_v   = mag_r;
    bcd_v   = bcd_r;
    nd_v    = ndig_r;
    top_idx = '0;
    top_nz  = 1'b0;
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      for (int d = 0; d < MAX_DIGITS; d++) begin
        if (bcd_v[d*4 +: 4] >= 4'd5) begin
          bcd_v[d*4 +: 4] = bcd_v[d*4 +: 4] + 4'd3;
        end
      end
      bcd_v = {bcd_v[BCD_WIDTH-2:0], mag_v[MAG_WIDTH-1]};
      mag_v = {mag_v[MAG_WIDTH-2:0], 1'b0};
      // a doubling adds at most one digit, always just above the current top
      top_idx = nd_v[DIG_IDX_W-1:0];
      top_nz  = 1'b0;
      if (nd_v < DIG_CNT_W'(MAX_DIGITS)) begin
        top_nz = (bcd_v[{top_idx, 2'b00} +: 4] != 4'd0);
      end
      if (top_nz) begin
        nd_v = nd_v + 1'b1;
      end
    end
  end

  // load and step sequencing
  always_comb begin
    mag_nxt  = mag_r;
    bcd_nxt  = bcd_r;
    ndig_nxt = ndig_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (load) begin
      mag_nxt  = load_mag;
      bcd_nxt  = '0;
      ndig_nxt = DIG_CNT_W'(1);
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      mag_nxt  = mag_v;
      bcd_nxt  = bcd_v;
      ndig_nxt = nd_v;
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(NUM_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    bcd_r  <= bcd_nxt;
    ndig_r <= ndig_nxt;
    step_r <= step_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign bcd       = bcd_r;
  assign ndig      = ndig_r;

  `ASSERT_ALWAYS(a_done_not_busy, !(done_r && busy_r), "done while still converting")
  `ASSERT_ALWAYS(a_ndig_range, !busy_r || (ndig_r != '0 && ndig_r <= DIG_CNT_W'(MAX_DIGITS)), "digit count out of range")
  `ASSERT_NEXT(a_load_starts, load, busy_r, "load did not start conversion")

endmodule

`default_nettype wire

>>> rtl/integer_to_decimal_ascii_unit.sv
`default_nettype none

`include "assert_macros.svh"

// Converts one signed two's complement integer per item into its decimal ASCII
// text, one character per output item, most significant first, with a leading
// '-' for negative values and last set on the final digit; zero gives "0" and
// the most negative value converts exactly. An accepted item passes through
// the shift-and-add-3 unit, which takes four magnitude bits per cycle, then
// hands its digits over to the sequencer, which moves one character per cycle
// into the output register while that register is free. The input is not
// ready while an item converts or emits; the last character may still wait in
// the output register when the next item enters.
module integer_to_decimal_ascii_unit (
  input  logic        clk,
  input  logic        rst_n,
  i2da_in_if.sink     in_chan,
  i2da_out_if.source  out_chan
);
  import i2da_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_EMIT
  } state_t;

  state_t               state_r, state_nxt;
  logic                 neg_r, neg_nxt;
  logic                 sign_pend_r, sign_pend_nxt;
  logic [DIG_IDX_W-1:0] ptr_r, ptr_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]    out_char_r, out_char_nxt;
  logic                 out_last_r, out_last_nxt;

  logic [VALUE_WIDTH-1:0] raw_u;
  logic [VALUE_WIDTH-1:0] mag_abs;
  logic                   in_acc;
  logic                   out_free;
  logic                   dab_load;
  dabble_stat_t           dab_stat;
  logic [BCD_WIDTH-1:0]   dab_bcd;
  logic [DIG_CNT_W-1:0]   dab_ndig;
  logic [3:0]             cur_digit;

  // unsigned magnitude, exact for the most negative value
  assign raw_u   = in_chan.value;
  assign mag_abs = raw_u[VALUE_WIDTH-1] ? (~raw_u + 1'b1) : raw_u;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && (state_r == ST_IDLE);
  assign dab_load      = in_acc;
  assign out_free      = !out_valid_r || out_chan.ready;
  assign cur_digit     = dab_bcd[{ptr_r, 2'b00} +: 4];

  i2da_dabble u_dabble (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (dab_load),
    .load_mag (MAG_WIDTH'(mag_abs)),
    .stat     (dab_stat),
    .bcd      (dab_bcd),
    .ndig     (dab_ndig)
  );

  // sequencer and output register
  always_comb begin
    state_nxt     = state_r;
    neg_nxt       = neg_r;
    sign_pend_nxt = sign_pend_r;
    ptr_nxt       = ptr_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          neg_nxt   = raw_u[VALUE_WIDTH-1];
          state_nxt = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        if (dab_stat.done) begin
          ptr_nxt       = DIG_IDX_W'(dab_ndig - 1'b1);
          sign_pend_nxt = neg_r;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (sign_pend_r) begin
            out_char_nxt  = CHAR_MINUS;
            out_last_nxt  = 1'b0;
            sign_pend_nxt = 1'b0;
          end else begin
            out_char_nxt = CHAR_ZERO + {4'd0, cur_digit};
            out_last_nxt = (ptr_r == '0);
            if (ptr_r == '0) begin
              state_nxt = ST_IDLE;
            end else begin
              ptr_nxt = ptr_r - 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    ptr_r      <= ptr_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sign_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sign_pend_r <= sign_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.character = out_char_r;
  assign out_chan.last      = out_last_r;

  `ASSERT_ALWAYS(a_ready_unit_free, !in_chan.ready || !dab_stat.busy, "input ready while converting")
  `ASSERT_NEXT(a_accept_converts, in_chan.valid && in_chan.ready, dab_stat.busy && state_r == ST_CONVERT, "accepted item not converting")
  `ASSERT_ALWAYS(a_last_is_digit, !(out_valid_r && out_last_r) || (out_char_r >= CHAR_ZERO && out_char_r <= CHAR_NINE), "last character is not a digit")
  `ASSERT_ALWAYS(a_minus_not_last, !(out_valid_r && out_char_r == CHAR_MINUS) || !out_last_r, "minus sign flagged last")

endmodule

`default_nettype wire
